### rtl/ami_pkg.sv
// Shared types and constants for the affine matrix inverse block.
// Used by every module under rtl; depends on nothing else.
package ami_pkg;

    localparam int FX_W       = 32;   // Q16.16 field width
    localparam int THR_W      = 31;   // threshold register width
    localparam int COF_W      = 64;   // cofactor, exact Q32.32
    localparam int DET_W      = 98;   // signed determinant, Q48.48
    localparam int DMAG_W     = 97;   // determinant magnitude
    localparam int NUM_W      = 98;   // rounded dividend
    localparam int QB_W       = 33;   // quotient bits kept before saturation
    localparam int DIV_STAGES = QB_W; // one quotient bit per stage
    localparam int REM_W      = DMAG_W + QB_W;

    localparam logic [FX_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic signed [FX_W-1:0] in_r0c0;
        logic signed [FX_W-1:0] in_r0c1;
        logic signed [FX_W-1:0] in_r0c2;
        logic signed [FX_W-1:0] in_r1c0;
        logic signed [FX_W-1:0] in_r1c1;
        logic signed [FX_W-1:0] in_r1c2;
        logic signed [FX_W-1:0] in_r2c0;
        logic signed [FX_W-1:0] in_r2c1;
        logic signed [FX_W-1:0] in_r2c2;
        logic signed [FX_W-1:0] in_tx;
        logic signed [FX_W-1:0] in_ty;
        logic signed [FX_W-1:0] in_tz;
    } ami_in_t;

    typedef struct packed {
        logic signed [FX_W-1:0] out_r0c0;
        logic signed [FX_W-1:0] out_r0c1;
        logic signed [FX_W-1:0] out_r0c2;
        logic signed [FX_W-1:0] out_r1c0;
        logic signed [FX_W-1:0] out_r1c1;
        logic signed [FX_W-1:0] out_r1c2;
        logic signed [FX_W-1:0] out_r2c0;
        logic signed [FX_W-1:0] out_r2c1;
        logic signed [FX_W-1:0] out_r2c2;
        logic signed [FX_W-1:0] out_tx;
        logic signed [FX_W-1:0] out_ty;
        logic signed [FX_W-1:0] out_tz;
    } ami_out_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [8:0][COF_W-1:0] cof;   // cofactors, row-major, signed
        logic [2:0][FX_W-1:0]  t;     // translation, signed
        logic [DMAG_W-1:0]     dmag;
        logic                  det_neg;
        logic                  singular;
    } ami_front_item_t;

endpackage

### rtl/affine_matrix_inverse.sv
// Top level of the affine matrix inverse block.
// Depends on ami_pkg, ami_front, ami_queue and ami_back.
//
// Usage:
// The block inverts the upper three rows of an affine 4x4 transform given as
// twelve signed Q16.16 values. A matrix transfers in at a rising edge where
// push is high and full is low. Results come out in order, like a queue: the
// oldest result sits on the result port while empty is low, and it transfers
// out at an edge where pop is high and empty is low.
// The det_threshold register is written over its own channel (cfg_valid,
// cfg_ready, cfg_data); cfg_ready is always high. Write it only while idle.
// Throughput is one matrix per cycle while the receiver keeps popping. A matrix
// passes seven front stages for cofactors and determinant, the middle queue,
// and forty back stages, of which thirty-three are the bit-per-stage divider.
// When the receiver stops popping, the result buffer fills, the back part
// holds, the middle queue fills and full rises; nothing is lost.
// Reset empties all queues and clears the threshold to zero.
module affine_matrix_inverse
    import ami_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  ami_in_t          item,
    input  logic             pop,
    output logic             empty,
    output ami_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    logic [THR_W-1:0] det_threshold_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    ami_front_item_t  q_wr_item;
    ami_front_item_t  q_rd_item;

    // The threshold register takes every write; the channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            det_threshold_reg <= cfg_data;
        end
    end

    // Front part: cofactors, determinant and the singular test.
    ami_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .item          (item),
        .det_threshold (det_threshold_reg),
        .q_full        (q_full),
        .full          (full),
        .q_push        (q_push),
        .q_item        (q_wr_item)
    );

    // The short queue lets the front and back parts stall independently.
    ami_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_item (q_wr_item),
        .rd      (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    // Back part: division, saturation, inverse translation and result buffer.
    ami_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_rd_item),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

### rtl/ami_queue.sv
// Two-entry queue between the front and back parts of the matrix inverse.
// Depends on ami_pkg for the classified item type.
module ami_queue
    import ami_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  ami_front_item_t wr_item,
    input  logic            rd,
    output logic            full,
    output logic            empty,
    output ami_front_item_t rd_item
);

    ami_front_item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr;
        rd_ptr_next = rd_ptr_reg ^ rd;
        count_next  = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### rtl/ami_front.sv
// Front part: accepts matrices, forms cofactors and the determinant, and
// classifies each matrix as singular or not. Depends on ami_pkg.
module ami_front
    import ami_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ami_in_t          item,
    input  logic [THR_W-1:0] det_threshold,
    input  logic             q_full,
    output logic             full,
    output logic             q_push,
    output ami_front_item_t  q_item
);

    localparam int FRONT_STAGES = 7;
    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    typedef struct packed {
        logic [2:0][FX_W-1:0]  a0;
        logic [2:0][FX_W-1:0]  t;
        logic [8:0][COF_W-1:0] pa;
        logic [8:0][COF_W-1:0] pb;
    } f1_t;

    typedef struct packed {
        logic [2:0][FX_W-1:0]  a0;
        logic [2:0][FX_W-1:0]  t;
        logic [8:0][COF_W-1:0] cof;
    } f2_t;

    typedef struct packed {
        logic [2:0][COF_W-1:0] ph;
        logic [2:0][COF_W:0]   pl;
        logic [2:0][FX_W-1:0]  t;
        logic [8:0][COF_W-1:0] cof;
    } f3_t;

    typedef struct packed {
        logic [COF_W+1:0]      sum_hi;
        logic [COF_W+2:0]      sum_lo;
        logic [2:0][FX_W-1:0]  t;
        logic [8:0][COF_W-1:0] cof;
    } f4_t;

    typedef struct packed {
        logic [DET_W-1:0]      det;
        logic [2:0][FX_W-1:0]  t;
        logic [8:0][COF_W-1:0] cof;
    } f5_t;

    logic                    en;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [8:0][FX_W-1:0]    a_in;
    f1_t                     f1_reg, f1_next;
    f2_t                     f2_reg, f2_next;
    f3_t                     f3_reg, f3_next;
    f4_t                     f4_reg, f4_next;
    f5_t                     f5_reg, f5_next;
    ami_front_item_t         f6_reg, f6_next;
    ami_front_item_t         f7_reg, f7_next;

    assign en     = !q_full;
    assign full   = q_full;
    assign q_push = en && vld_reg[FRONT_STAGES-1];
    assign q_item = f7_reg;

    assign a_in = {item.in_r2c2, item.in_r2c1, item.in_r2c0,
                   item.in_r1c2, item.in_r1c1, item.in_r1c0,
                   item.in_r0c2, item.in_r0c1, item.in_r0c0};

    // The two products of each cyclic minor; the cyclic order carries the sign.
    always_comb
    begin
        f1_next.a0 = a_in[2:0];
        f1_next.t  = {item.in_tz, item.in_ty, item.in_tx};
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                f1_next.pa[i*3+j] = $signed(a_in[NXT1[i]*3+NXT1[j]])
                                  * $signed(a_in[NXT2[i]*3+NXT2[j]]);
                f1_next.pb[i*3+j] = $signed(a_in[NXT1[i]*3+NXT2[j]])
                                  * $signed(a_in[NXT2[i]*3+NXT1[j]]);
            end
        end
    end

    always_comb
    begin
        f2_next.a0 = f1_reg.a0;
        f2_next.t  = f1_reg.t;
        for (int k = 0; k < 9; k++)
        begin
            f2_next.cof[k] = f1_reg.pa[k] - f1_reg.pb[k];
        end
    end

    // Row 0 times its cofactors, split into a signed high and unsigned low half.
    always_comb
    begin
        f3_next.t   = f2_reg.t;
        f3_next.cof = f2_reg.cof;
        for (int j = 0; j < 3; j++)
        begin
            f3_next.ph[j] = $signed(f2_reg.a0[j]) * $signed(f2_reg.cof[j][COF_W-1:FX_W]);
            f3_next.pl[j] = $signed(f2_reg.a0[j]) * $signed({1'b0, f2_reg.cof[j][FX_W-1:0]});
        end
    end

    always_comb
    begin
        f4_next.t      = f3_reg.t;
        f4_next.cof    = f3_reg.cof;
        f4_next.sum_hi = (COF_W+2)'($signed(f3_reg.ph[0]))
                       + (COF_W+2)'($signed(f3_reg.ph[1]))
                       + (COF_W+2)'($signed(f3_reg.ph[2]));
        f4_next.sum_lo = (COF_W+3)'($signed(f3_reg.pl[0]))
                       + (COF_W+3)'($signed(f3_reg.pl[1]))
                       + (COF_W+3)'($signed(f3_reg.pl[2]));
    end

    always_comb
    begin
        f5_next.t   = f4_reg.t;
        f5_next.cof = f4_reg.cof;
        f5_next.det = $signed({f4_reg.sum_hi, {FX_W{1'b0}}})
                    + DET_W'($signed(f4_reg.sum_lo));
    end

    always_comb
    begin
        f6_next.t        = f5_reg.t;
        f6_next.cof      = f5_reg.cof;
        f6_next.det_neg  = f5_reg.det[DET_W-1];
        f6_next.dmag     = f5_reg.det[DET_W-1] ? DMAG_W'(-f5_reg.det) : DMAG_W'(f5_reg.det);
        f6_next.singular = 1'b0;
    end

    always_comb
    begin
        f7_next          = f6_reg;
        f7_next.singular = (f6_reg.dmag <= DMAG_W'({det_threshold, {FX_W{1'b0}}}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
            f5_reg <= f5_next;
            f6_reg <= f6_next;
            f7_reg <= f7_next;
        end
    end

endmodule

### rtl/ami_back.sv
// Back part: divides the cofactors by the determinant one quotient bit per
// stage, saturates, forms the inverse translation and buffers the results.
// Depends on ami_pkg.
module ami_back
    import ami_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  ami_front_item_t q_item,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output ami_out_t        result
);

    // B0, the divider input stage and DIV_STAGES steps, saturation, four translation stages
    localparam int BACK_STAGES = 1 + (DIV_STAGES + 1) + 5;

    typedef struct packed {
        logic [8:0][NUM_W-1:0] num;
        logic [8:0]            neg;
        logic [DMAG_W-1:0]     dmag;
        logic                  singular;
        logic [2:0][FX_W-1:0]  t;
    } b0_t;

    typedef struct packed {
        logic [8:0][REM_W-1:0] rem;
        logic [8:0][QB_W-1:0]  q;
        logic [8:0]            ovf;
        logic [8:0]            neg;
        logic [DMAG_W-1:0]     dmag;
        logic                  singular;
        logic [2:0][FX_W-1:0]  t;
    } div_t;

    typedef struct packed {
        logic [8:0][FX_W-1:0]  m;
        logic [2:0][FX_W-1:0]  t;
        logic                  singular;
    } mat_t;

    typedef struct packed {
        logic [8:0][FX_W-1:0]  m;
        logic [8:0][COF_W-1:0] prod;
        logic                  singular;
    } t1_t;

    typedef struct packed {
        logic [8:0][FX_W-1:0]  m;
        logic [2:0][COF_W+1:0] sum;
        logic                  singular;
    } t2_t;

    typedef struct packed {
        logic [8:0][FX_W-1:0]  m;
        logic [2:0][COF_W+1:0] mag;
        logic [2:0]            neg;
        logic                  singular;
    } t3_t;

    logic                   en;
    logic [BACK_STAGES-1:0] vld_reg;
    b0_t                    b0_reg, b0_next;
    div_t                   dv_reg  [DIV_STAGES+1];
    div_t                   dv_next [DIV_STAGES+1];
    mat_t                   s_reg, s_next;
    t1_t                    t1_reg, t1_next;
    t2_t                    t2_reg, t2_next;
    t3_t                    t3_reg, t3_next;
    ami_out_t               t4_reg, t4_next;
    ami_out_t               ob_reg [2];
    logic                   ob_wr, ob_rd;
    logic                   ob_wr_ptr_reg, ob_rd_ptr_reg;
    logic [1:0]             ob_count_reg, ob_count_next;

    assign en    = (ob_count_reg != 2'd2);
    assign q_pop = en && !q_empty;

    // Rounded dividend |C| * 2^32 + |det| / 2; the inverse takes the transposed cofactor.
    always_comb
    begin
        logic [COF_W-1:0] cf;
        logic [COF_W-1:0] cm;
        cf = '0;
        cm = '0;
        b0_next.dmag     = q_item.dmag;
        b0_next.singular = q_item.singular;
        b0_next.t        = q_item.t;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cf = q_item.cof[j*3+i];
                cm = cf[COF_W-1] ? (~cf + COF_W'(1)) : cf;
                b0_next.num[i*3+j] = NUM_W'({cm, {FX_W{1'b0}}}) + NUM_W'(q_item.dmag >> 1);
                b0_next.neg[i*3+j] = cf[COF_W-1] ^ q_item.det_neg;
            end
        end
    end

    // A quotient at or above 2^QB_W saturates in any case.
    always_comb
    begin
        dv_next[0].dmag     = b0_reg.dmag;
        dv_next[0].singular = b0_reg.singular;
        dv_next[0].t        = b0_reg.t;
        dv_next[0].neg      = b0_reg.neg;
        dv_next[0].q        = '0;
        for (int k = 0; k < 9; k++)
        begin
            dv_next[0].rem[k] = REM_W'(b0_reg.num[k]);
            dv_next[0].ovf[k] = REM_W'(b0_reg.num[k]) >= (REM_W'(b0_reg.dmag) << QB_W);
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        always_comb
        begin
            logic [REM_W-1:0] dsh;
            dsh = REM_W'(dv_reg[s].dmag) << (QB_W - 1 - s);
            dv_next[s+1] = dv_reg[s];
            for (int k = 0; k < 9; k++)
            begin
                if (dv_reg[s].rem[k] >= dsh)
                begin
                    dv_next[s+1].rem[k]            = dv_reg[s].rem[k] - dsh;
                    dv_next[s+1].q[k][QB_W-1-s]    = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[s+1] <= dv_next[s+1];
            end
        end
    end

    // Saturation of the linear part; a singular matrix gives the identity.
    always_comb
    begin
        logic [QB_W-1:0] lim;
        logic [QB_W-1:0] mg;
        lim = '0;
        mg  = '0;
        s_next.t        = dv_reg[DIV_STAGES].t;
        s_next.singular = dv_reg[DIV_STAGES].singular;
        for (int k = 0; k < 9; k++)
        begin
            lim = dv_reg[DIV_STAGES].neg[k] ? 33'd2147483648 : 33'd2147483647;
            mg  = (dv_reg[DIV_STAGES].ovf[k] || dv_reg[DIV_STAGES].q[k] > lim)
                ? lim : dv_reg[DIV_STAGES].q[k];
            s_next.m[k] = dv_reg[DIV_STAGES].neg[k] ? (~mg[FX_W-1:0] + FX_W'(1))
                                                    : mg[FX_W-1:0];
            if (dv_reg[DIV_STAGES].singular)
            begin
                s_next.m[k] = (k == 0 || k == 4 || k == 8) ? ONE_Q16 : '0;
            end
        end
    end

    always_comb
    begin
        t1_next.m        = s_reg.m;
        t1_next.singular = s_reg.singular;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                t1_next.prod[i*3+j] = $signed(s_reg.m[i*3+j]) * $signed(s_reg.t[j]);
            end
        end
    end

    always_comb
    begin
        t2_next.m        = t1_reg.m;
        t2_next.singular = t1_reg.singular;
        for (int i = 0; i < 3; i++)
        begin
            t2_next.sum[i] = (COF_W+2)'($signed(t1_reg.prod[i*3]))
                           + (COF_W+2)'($signed(t1_reg.prod[i*3+1]))
                           + (COF_W+2)'($signed(t1_reg.prod[i*3+2]));
        end
    end

    // The translation is the negated sum, so its sign is set by a positive sum.
    always_comb
    begin
        t3_next.m        = t2_reg.m;
        t3_next.singular = t2_reg.singular;
        for (int i = 0; i < 3; i++)
        begin
            t3_next.neg[i] = !t2_reg.sum[i][COF_W+1] && (t2_reg.sum[i] != '0);
            t3_next.mag[i] = t2_reg.sum[i][COF_W+1] ? (~t2_reg.sum[i] + (COF_W+2)'(1))
                                                    : t2_reg.sum[i];
        end
    end

    always_comb
    begin
        logic [2:0][FX_W-1:0]  tr;
        logic [COF_W+1:0]      rnd;
        logic [COF_W-15:0]     lim;
        logic [COF_W-15:0]     mg;
        tr  = '0;
        rnd = '0;
        lim = '0;
        mg  = '0;
        for (int i = 0; i < 3; i++)
        begin
            rnd   = t3_reg.mag[i] + (COF_W+2)'(32'h8000);
            lim   = t3_reg.neg[i] ? (COF_W-14)'(33'd2147483648) : (COF_W-14)'(33'd2147483647);
            mg    = (rnd[COF_W+1:16] > lim) ? lim : rnd[COF_W+1:16];
            tr[i] = t3_reg.neg[i] ? (~mg[FX_W-1:0] + FX_W'(1)) : mg[FX_W-1:0];
            if (t3_reg.singular)
            begin
                tr[i] = '0;
            end
        end
        t4_next.out_r0c0 = t3_reg.m[0];
        t4_next.out_r0c1 = t3_reg.m[1];
        t4_next.out_r0c2 = t3_reg.m[2];
        t4_next.out_r1c0 = t3_reg.m[3];
        t4_next.out_r1c1 = t3_reg.m[4];
        t4_next.out_r1c2 = t3_reg.m[5];
        t4_next.out_r2c0 = t3_reg.m[6];
        t4_next.out_r2c1 = t3_reg.m[7];
        t4_next.out_r2c2 = t3_reg.m[8];
        t4_next.out_tx   = tr[0];
        t4_next.out_ty   = tr[1];
        t4_next.out_tz   = tr[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BACK_STAGES-2:0], !q_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg    <= b0_next;
            dv_reg[0] <= dv_next[0];
            s_reg     <= s_next;
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            t4_reg    <= t4_next;
        end
    end

    // Two-entry result buffer; the pipeline holds only while it is full.
    assign ob_wr         = en && vld_reg[BACK_STAGES-1];
    assign ob_rd         = pop && (ob_count_reg != 2'd0);
    assign ob_count_next = ob_count_reg + {1'b0, ob_wr} - {1'b0, ob_rd};
    assign empty         = (ob_count_reg == 2'd0);
    assign result        = ob_reg[ob_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_ptr_reg <= 1'b0;
            ob_rd_ptr_reg <= 1'b0;
            ob_count_reg  <= 2'd0;
        end
        else
        begin
            ob_wr_ptr_reg <= ob_wr_ptr_reg ^ ob_wr;
            ob_rd_ptr_reg <= ob_rd_ptr_reg ^ ob_rd;
            ob_count_reg  <= ob_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_wr)
        begin
            ob_reg[ob_wr_ptr_reg] <= t4_reg;
        end
    end

endmodule

### tb/tb_affine_matrix_inverse.sv
// Self-checking testbench for affine_matrix_inverse: directed and random matrices,
// several threshold settings and random stalls on both sides.
// Depends on rtl/ami_pkg.sv and rtl/affine_matrix_inverse.sv.
module tb_affine_matrix_inverse;
    timeunit 1ns;
    timeprecision 1ps;
    import ami_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic [11:0][FX_W-1:0] words_t;

    // The inverse predictor keeps its own copy of the threshold register and a
    // queue of the results that the block still owes.
    class inverse_scoreboard;
        logic [THR_W-1:0] threshold;
        ami_out_t         owed_q[$];
        int               errors;
        int               checked;
        int               singular_seen;

        function new();
            threshold     = '0;
            errors        = 0;
            checked       = 0;
            singular_seen = 0;
        endfunction

        function wide_t widen(longint v);
            return v;
        endfunction

        // Rounded magnitude plus sign, clamped to the signed 32-bit range.
        function logic [FX_W-1:0] clamp(wide_t mag, bit neg);
            wide_t lim;
            wide_t m;
            lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
            m = (mag > lim) ? lim : mag;
            return neg ? -m[FX_W-1:0] : m[FX_W-1:0];
        endfunction

        function void note_matrix(ami_in_t mtx);
            words_t                  w;
            words_t                  r;
            logic signed [FX_W-1:0]  a[3][3];
            logic signed [FX_W-1:0]  t[3];
            logic signed [FX_W-1:0]  b[3][3];
            longint                  cof[3][3];
            wide_t                   det, dmag, thr, cm, num, q, s;
            bit                      neg;
            int                      i1, i2, j1, j2;
            w = mtx;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    a[i][j] = w[11 - (i * 3 + j)];
                t[i] = w[2 - i];
            end
            // Cyclic minors already carry the cofactor sign; 64-bit wrap as in hardware.
            for (int i = 0; i < 3; i++)
            begin
                i1 = (i + 1) % 3;
                i2 = (i + 2) % 3;
                for (int j = 0; j < 3; j++)
                begin
                    j1 = (j + 1) % 3;
                    j2 = (j + 2) % 3;
                    cof[i][j] = longint'(a[i1][j1]) * longint'(a[i2][j2])
                              - longint'(a[i1][j2]) * longint'(a[i2][j1]);
                end
            end
            det = widen(a[0][0]) * widen(cof[0][0]) + widen(a[0][1]) * widen(cof[0][1])
                + widen(a[0][2]) * widen(cof[0][2]);
            dmag = (det < 0) ? -det : det;
            thr = {97'b0, threshold};
            thr = thr << 32;
            r = '0;
            if (dmag <= thr)
            begin
                r[11] = ONE_Q16;
                r[7]  = ONE_Q16;
                r[3]  = ONE_Q16;
                singular_seen++;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                    begin
                        cm = (cof[j][i] < 0) ? -widen(cof[j][i]) : widen(cof[j][i]);
                        num = (cm << 32) + (dmag >> 1);
                        q = num / dmag;
                        b[i][j] = clamp(q, (cof[j][i] < 0) != (det < 0));
                        r[11 - (i * 3 + j)] = b[i][j];
                    end
                // Translation uses the already clamped inverse entries.
                for (int i = 0; i < 3; i++)
                begin
                    s = widen(b[i][0]) * widen(t[0]) + widen(b[i][1]) * widen(t[1])
                      + widen(b[i][2]) * widen(t[2]);
                    s = -s;
                    neg = s < 0;
                    s = ((neg ? -s : s) + 128'h8000) >> 16;
                    r[2 - i] = clamp(s, neg);
                end
            end
            owed_q = {owed_q, ami_out_t'(r)};
        endfunction

        function void check_result(ami_out_t got);
            words_t gw;
            words_t ew;
            gw = got;
            checked++;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: result %h arrived with nothing owed", $realtime, got);
                return;
            end
            ew = owed_q.pop_front();
            for (int k = 11; k >= 0; k--)
                if (gw[k] !== ew[k])
                begin
                    errors++;
                    $display("%0t: field %0d expected %h actual %h",
                             $realtime, 11 - k, ew[k], gw[k]);
                end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    ami_in_t          item;
    logic             pop;
    logic             empty;
    ami_out_t         result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    inverse_scoreboard sb;
    bit  steady;          // last part of the run: no idling on either side
    int  hold_cycles;     // long receiver hold-off, counted down by the receiver
    int  quiet_cycles;    // cycles without any transfer, for the watchdog
    int  matrices_sent;

    affine_matrix_inverse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: checks each result transfer and pops with random idle bursts,
    // or holds off entirely while a long hold-off is pending.
    initial
    begin
        int gap;
        gap = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(result);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                pop <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(0, 7);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: a stretch with no transfer at all means the block is stuck.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one matrix and waits for its transfer, then may idle for a burst.
    task automatic send_matrix(ami_in_t mtx);
        push <= 1'b1;
        item <= mtx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_matrix(mtx);
        matrices_sent++;
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Waits until every owed result has transferred, then lets the pipeline drain.
    task automatic drain();
        push <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.threshold = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FX_W-1:0] pick_value(int kind);
        int sh;
        case (kind)
            0: return $urandom();
            1:
            begin
                sh = $urandom_range(2, 20);
                return $signed($urandom_range(0, (1 << sh) - 1)) - (1 << (sh - 1));
            end
            default:
                case ($urandom_range(0, 5))
                    0: return 32'h0;
                    1: return 32'h8000_0000;
                    2: return 32'h7FFF_FFFF;
                    3: return ONE_Q16;
                    4: return -ONE_Q16;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    // Most matrices are small, many with a strengthened diagonal; some are exactly singular,
    // some are raw random bits or built from extreme values.
    function automatic ami_in_t random_matrix();
        words_t w;
        int     style;
        style = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++)
            w[k] = pick_value(style < 2 ? 0 : (style == 2 ? 2 : 1));
        if (style >= 3 && style <= 6)
        begin
            // Strengthen the diagonal so the determinant stays well away from zero.
            w[11] = w[11] + (32'sd4 <<< 16);
            w[7]  = w[7]  - (32'sd3 <<< 16);
            w[3]  = w[3]  + (32'sd5 <<< 16);
        end
        else if (style == 7)
        begin
            // Row 2 repeats row 0: determinant is exactly zero.
            w[5] = w[11];
            w[4] = w[10];
            w[3] = w[9];
        end
        return ami_in_t'(w);
    endfunction

    function automatic ami_in_t build(logic [FX_W-1:0] d0, logic [FX_W-1:0] d1,
                                      logic [FX_W-1:0] d2, logic [FX_W-1:0] off,
                                      logic [FX_W-1:0] tr);
        words_t w;
        w = '0;
        for (int k = 3; k < 12; k++)
            w[k] = off;
        w[11] = d0;
        w[7]  = d1;
        w[3]  = d2;
        w[2]  = tr;
        w[1]  = -tr;
        w[0]  = tr;
        return ami_in_t'(w);
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_matrix(random_matrix());
    endtask

    initial
    begin
        sb = new();
        steady       = 1'b0;
        hold_cycles  = 0;
        quiet_cycles = 0;
        matrices_sent = 0;
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, threshold at its reset value of zero.
        send_matrix(build(ONE_Q16, ONE_Q16, ONE_Q16, 32'h0, 32'h0));
        send_matrix(build(ONE_Q16, ONE_Q16, ONE_Q16, 32'h0, 32'h0003_8000));
        send_matrix(build(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF));
        send_matrix(build(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                          32'h8000_0000));
        send_matrix(build(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                          32'h7FFF_FFFF));
        send_matrix(build(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000));
        send_matrix(build(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(build(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0,
                          32'h0001_0000));
        send_matrix(build(32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 32'h0,
                          32'hFFFF_FFFF));
        send_matrix(build(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0,
                          32'h0000_0001));
        send_matrix(build(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0,
                          32'h0001_0000));
        send_matrix(build(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0,
                          32'h7FFF_FFFF));
        send_matrix(build(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h0));
        send_matrix(build(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                          32'h8000_0000));
        send_matrix(ami_in_t'({12{32'hFFFF_FFFF}}));
        send_matrix(ami_in_t'({12{32'h5555_5555}}));
        send_matrix(ami_in_t'({12{32'hAAAA_AAAA}}));
        drain();

        // Largest threshold: only large determinants survive.
        write_threshold(31'h7FFF_FFFF);
        send_matrix(build(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0,
                          32'h0001_0000));
        send_matrix(build(32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'h0, 32'h0));
        random_phase(200);
        drain();

        // One unit in Q16.16: the threshold sits right at det = 1.0.
        write_threshold(31'h0001_0000);
        send_matrix(build(ONE_Q16, ONE_Q16, ONE_Q16, 32'h0, 32'h0));
        send_matrix(build(32'h0001_0001, ONE_Q16, ONE_Q16, 32'h0, 32'h0));
        // The receiver holds off long enough for the block to fill and stall.
        hold_cycles = 400;
        random_phase(250);
        drain();

        write_threshold(31'h0000_0005);
        random_phase(250);
        drain();

        // Back to zero, with no idling for the last stretch.
        write_threshold(31'h0);
        random_phase(100);
        steady = 1'b1;
        random_phase(200);
        drain();

        $display("Sent %0d matrices over four threshold settings; %0d results checked,",
                 matrices_sent, sb.checked);
        $display("%0d of them taken as singular, with a long receiver hold-off.",
                 sb.singular_seen);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### affine_matrix_inverse.f
rtl/ami_pkg.sv
rtl/ami_queue.sv
rtl/ami_front.sv
rtl/ami_back.sv
rtl/affine_matrix_inverse.sv
tb/tb_affine_matrix_inverse.sv
